FILE: rtl/core/sbc_pkg.sv
// ----------------------------------------------------------------------------
// Sprite box collision table package
// Shared types and constants for the collision table, its cells and channels.
// ----------------------------------------------------------------------------
`default_nettype none

package sbc_pkg;

    // Coordinates inside the block: signed Q15.4 with headroom for the far edge.
    localparam int unsigned COORD_W = 19;
    localparam int unsigned KIND_W  = 4;
    localparam int unsigned MASK_W  = 16;
    localparam int unsigned SLOT_W  = 6;
    localparam int unsigned ACT_W   = 7;
    localparam int unsigned KINDS   = 16;

    localparam logic signed [COORD_W-1:0] ONE_PIXEL = 19'sd16;

    // Item operations.
    localparam logic [1:0] OP_STORE   = 2'd0;
    localparam logic [1:0] OP_COLLIDE = 2'd1;
    localparam logic [1:0] OP_BOUNCE  = 2'd2;

    // Nudge directions of a collide query.
    localparam logic [2:0] NUDGE_RIGHT = 3'd1;
    localparam logic [2:0] NUDGE_LEFT  = 3'd2;
    localparam logic [2:0] NUDGE_DOWN  = 3'd3;
    localparam logic [2:0] NUDGE_UP    = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] REG_ACTIVE_SLOTS = 2'd0;
    localparam logic [1:0] REG_COLLIDE_MASK = 2'd1;
    localparam logic [1:0] REG_BOUNCE_MASK  = 2'd2;

    typedef struct packed {
        logic [1:0]        op;
        logic [SLOT_W-1:0] slot;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] ofs_x;
        logic signed [15:0] ofs_y;
        logic [14:0]       box_w;
        logic [14:0]       box_h;
        logic [KIND_W-1:0] kind_id;
        logic [2:0]        nudge_dir;
    } t_query;

    typedef struct packed {
        logic hit;
    } t_result;

    typedef struct packed {
        logic [1:0]  index;
        logic [15:0] value;
    } t_cfg_wr;

    // Box as held by a cell: edges are precomputed so a test is compares only.
    typedef struct packed {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic signed [COORD_W-1:0] right;
        logic signed [COORD_W-1:0] bottom;
        logic [KIND_W-1:0]         kind;
        logic                      nonempty;
    } t_box;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        t_box              box;
    } t_wr;

    // Query box broadcast to all cells while the token walks the row.
    typedef struct packed {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic signed [COORD_W-1:0] right;
        logic signed [COORD_W-1:0] bottom;
        logic [MASK_W-1:0]         mask;
        logic [SLOT_W-1:0]         own_slot;
        logic [ACT_W-1:0]          active;
    } t_qbox;

    typedef struct packed {
        logic valid;
        logic hit;
    } t_token;

endpackage

`default_nettype wire

FILE: rtl/core/sbc_stream_if.sv
// ----------------------------------------------------------------------------
// Stream channel
// Valid/ready channel carrying one item of payload type T per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbc_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/sbc_cell.sv
// ----------------------------------------------------------------------------
// Collision table cell
// Holds one slot's box and tests it against the query as the token passes.
// ----------------------------------------------------------------------------
`default_nettype none

module sbc_cell #(
    parameter int unsigned IDX = 0
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire sbc_pkg::t_wr    i_wr,
    input  wire sbc_pkg::t_qbox  i_q,
    input  wire sbc_pkg::t_token i_tok,
    output sbc_pkg::t_token    o_tok
);
    // Wide enough for the cell index and for the slot and count fields.
    localparam int unsigned CW = $clog2(IDX + 1) + 8;
    localparam logic [CW-1:0] ID = CW'(IDX);

    sbc_pkg::t_box   r_box;
    sbc_pkg::t_token r_tok;
    logic            eligible;
    logic            overlap;

    always_ff @(posedge i_clk) begin
        if (i_wr.en && (ID == CW'(i_wr.slot))) begin
            r_box <= i_wr.box;
        end
    end

    always_comb begin
        eligible = (ID < CW'(i_q.active)) && (ID != CW'(i_q.own_slot))
                 && i_q.mask[r_box.kind] && r_box.nonempty;
        overlap  = ($signed(i_q.left) < $signed(r_box.right))
                 && ($signed(r_box.left) < $signed(i_q.right))
                 && ($signed(i_q.top) < $signed(r_box.bottom))
                 && ($signed(r_box.top) < $signed(i_q.bottom));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= i_tok.valid;
        end
        r_tok.hit <= i_tok.hit | (i_tok.valid & eligible & overlap);
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

FILE: rtl/core/sprite_box_collision_table.sv
// ----------------------------------------------------------------------------
// Sprite box collision table
// Box table with overlap queries, built as a row of one cell per sprite slot.
// ----------------------------------------------------------------------------
// Usage:
//   i_cfg takes register writes (active slot count, collide and bounce kind
//   masks); it is always ready. The user must write it only while the block is idle;
//   the block does not enforce this. i_query takes items: a store writes one slot's
//   box, a collide or bounce query asks whether any eligible stored box overlaps
//   the query box. o_result returns one item with hit per query and nothing for a
//   store.
// Timing:
//   Every item passes two input stages (edge sums, then far edges). A store
//   is written in the cycle after acceptance and the port is ready again right
//   after the write. A query token then walks the row of SLOTS cells, one cell
//   per cycle, into the output register. The port is ready again in the cycle
//   the result is presented, so the next item can be taken at its first edge.
// Reset clears the registers and all control; stored boxes stay undefined
// until written. When the receiver stalls, the result is held in the output
// register and a second result waits in a skid register; no new item is
// taken while the skid register is full.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_box_collision_table #(
    parameter int unsigned SLOTS = 64
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    sbc_stream_if.sink   i_cfg,
    sbc_stream_if.sink   i_query,
    sbc_stream_if.source o_result
);
    localparam int unsigned CW = sbc_pkg::COORD_W;

    // Configuration registers.
    logic [sbc_pkg::ACT_W-1:0]  r_active;
    logic [sbc_pkg::MASK_W-1:0] r_cmask;
    logic [sbc_pkg::MASK_W-1:0] r_bmask;

    // Control.
    logic r_run, n_run;
    logic r_ov, n_ov, r_oh, n_oh;
    logic r_sv, n_sv, r_sh, n_sh;

    // First stage: near edges with nudge applied.
    logic                        r_a_valid;
    logic [1:0]                  r_a_op;
    logic [sbc_pkg::SLOT_W-1:0]  r_a_slot;
    logic signed [CW-1:0]        r_a_left, r_a_top;
    logic [14:0]                 r_a_w, r_a_h;
    logic [sbc_pkg::KIND_W-1:0]  r_a_kind;
    logic [sbc_pkg::MASK_W-1:0]  r_a_mask;

    // Second stage: query broadcast to the cells.
    logic                        r_b_valid;
    sbc_pkg::t_qbox              r_q;

    logic                        in_acc;
    logic                        out_take;
    logic                        a_is_query;
    logic signed [CW-1:0]        dx, dy, n_left, n_top;
    logic [sbc_pkg::MASK_W-1:0]  n_mask;
    sbc_pkg::t_box               a_box;
    sbc_pkg::t_wr                wr;
    sbc_pkg::t_token             tok [SLOTS+1];

    assign in_acc        = i_query.valid & i_query.ready;
    assign out_take      = o_result.valid & o_result.ready;
    assign i_query.ready = ~r_run & ~r_sv;
    assign i_cfg.ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            r_cmask  <= '0;
            r_bmask  <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.index)
                sbc_pkg::REG_ACTIVE_SLOTS: r_active <= i_cfg.data.value[sbc_pkg::ACT_W-1:0];
                sbc_pkg::REG_COLLIDE_MASK: r_cmask  <= i_cfg.data.value;
                sbc_pkg::REG_BOUNCE_MASK:  r_bmask  <= i_cfg.data.value;
                default: ;
            endcase
        end
    end

    // Input decode: nudge offsets and kind mask.
    always_comb begin
        dx     = '0;
        dy     = '0;
        n_mask = '0;
        case (i_query.data.op)
            sbc_pkg::OP_COLLIDE: begin
                n_mask = r_cmask;
                case (i_query.data.nudge_dir)
                    sbc_pkg::NUDGE_RIGHT: dx = sbc_pkg::ONE_PIXEL;
                    sbc_pkg::NUDGE_LEFT:  dx = -sbc_pkg::ONE_PIXEL;
                    sbc_pkg::NUDGE_DOWN:  dy = sbc_pkg::ONE_PIXEL;
                    sbc_pkg::NUDGE_UP:    dy = -sbc_pkg::ONE_PIXEL;
                    default: ;
                endcase
            end
            sbc_pkg::OP_BOUNCE: begin
                n_mask = r_bmask;
                dy     = sbc_pkg::ONE_PIXEL;
            end
            default: ;
        endcase
        n_left = CW'(i_query.data.pos_x) + CW'(i_query.data.ofs_x) + dx;
        n_top  = CW'(i_query.data.pos_y) + CW'(i_query.data.ofs_y) + dy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= in_acc;
        end
        if (in_acc) begin
            r_a_op   <= i_query.data.op;
            r_a_slot <= i_query.data.slot;
            r_a_left <= n_left;
            r_a_top  <= n_top;
            r_a_w    <= i_query.data.box_w;
            r_a_h    <= i_query.data.box_h;
            r_a_kind <= i_query.data.kind_id;
            r_a_mask <= n_mask;
        end
    end

    // Second stage: far edges, shared by stores and queries.
    always_comb begin
        a_is_query     = (r_a_op == sbc_pkg::OP_COLLIDE) || (r_a_op == sbc_pkg::OP_BOUNCE);
        a_box.left     = r_a_left;
        a_box.top      = r_a_top;
        a_box.right    = r_a_left + $signed(CW'(r_a_w));
        a_box.bottom   = r_a_top + $signed(CW'(r_a_h));
        a_box.kind     = r_a_kind;
        a_box.nonempty = (r_a_w != '0) && (r_a_h != '0);
        wr.en          = r_a_valid && (r_a_op == sbc_pkg::OP_STORE);
        wr.slot        = r_a_slot;
        wr.box         = a_box;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid & a_is_query;
        end
        if (r_a_valid && a_is_query) begin
            r_q.left     <= a_box.left;
            r_q.top      <= a_box.top;
            r_q.right    <= a_box.right;
            r_q.bottom   <= a_box.bottom;
            r_q.own_slot <= r_a_slot;
            r_q.active   <= r_active;
            // An empty query box overlaps nothing; kinds past the limit never count.
            for (int k = 0; k < sbc_pkg::MASK_W; k++) begin
                r_q.mask[k] <= r_a_mask[k] & a_box.nonempty & (k < sbc_pkg::KINDS);
            end
        end
    end

    assign tok[0] = '{valid: r_b_valid, hit: 1'b0};

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        sbc_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_wr    (wr),
            .i_q     (r_q),
            .i_tok   (tok[g]),
            .o_tok   (tok[g+1])
        );
    end

    // Busy from acceptance until a non-query item ends or the token leaves the row.
    always_comb begin
        n_run = r_run;
        if (in_acc) begin
            n_run = 1'b1;
        end
        if (r_a_valid && !a_is_query) begin
            n_run = 1'b0;
        end
        if (tok[SLOTS].valid) begin
            n_run = 1'b0;
        end
    end

    // Output register with one skid entry behind it.
    always_comb begin
        n_ov = r_ov;
        n_oh = r_oh;
        n_sv = r_sv;
        n_sh = r_sh;
        if (out_take) begin
            n_ov = 1'b0;
        end
        if (r_sv && !n_ov) begin
            n_ov = 1'b1;
            n_oh = r_sh;
            n_sv = 1'b0;
        end
        if (tok[SLOTS].valid) begin
            if (!n_ov) begin
                n_ov = 1'b1;
                n_oh = tok[SLOTS].hit;
            end else begin
                n_sv = 1'b1;
                n_sh = tok[SLOTS].hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_ov  <= 1'b0;
            r_sv  <= 1'b0;
        end else begin
            r_run <= n_run;
            r_ov  <= n_ov;
            r_sv  <= n_sv;
        end
        r_oh <= n_oh;
        r_sh <= n_sh;
    end

    assign o_result.valid    = r_ov;
    assign o_result.data.hit = r_oh;

endmodule

`default_nettype wire

FILE: rtl/core/sbc_checker.sv
// ----------------------------------------------------------------------------
// Collision table port checker
// Watches the top level's ports for busy, result and hold behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module sbc_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire logic i_out_hit
);
    // An accepted item keeps the block busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready right after an accepted item");

    // No result can appear in the cycle after an item is taken.
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !$rose(i_out_valid))
        else $error("result appeared right after an accepted item");

    // A stalled result stays and keeps its value.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_hit)))
        else $error("stalled result dropped or changed");

endmodule

bind sprite_box_collision_table sbc_checker u_sbc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_query.valid),
    .i_in_ready  (i_query.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_hit   (o_result.data.hit)
);

`default_nettype wire

FILE: sim/sbc_tb_pkg.sv
// ----------------------------------------------------------------------------
// Sprite box collision table testbench package
// Holds a shadow copy of the box table and its registers. Each accepted item
// updates the copy or predicts the query's hit flag. Each returned result is
// checked against the oldest prediction.
// ----------------------------------------------------------------------------
package sbc_tb_pkg;

    import sbc_pkg::*;

    localparam int TABLE_SLOTS = 64;
    localparam int PX          = 16;  // one pixel in Q12.4

    // Operation code that the block must ignore.
    localparam logic [1:0] OP_IGNORED = 2'd3;

    // Nudge codes outside the named directions.
    localparam logic [2:0] NUDGE_NONE    = 3'd0;
    localparam logic [2:0] NUDGE_VOID_LO = 3'd5;
    localparam logic [2:0] NUDGE_VOID_HI = 3'd7;

    class box_table_shadow;
        logic signed [16:0] slot_left[TABLE_SLOTS];
        logic signed [16:0] slot_top[TABLE_SLOTS];
        logic [14:0]        slot_wide[TABLE_SLOTS];
        logic [14:0]        slot_tall[TABLE_SLOTS];
        logic [3:0]         slot_kind[TABLE_SLOTS];
        logic [6:0]         active_slots;
        logic [15:0]        collide_mask;
        logic [15:0]        bounce_mask;
        bit                 pending_hits[$];
        int unsigned        fail_count;

        function new();
            active_slots = '0;
            collide_mask = '0;
            bounce_mask  = '0;
            fail_count   = 0;
            foreach (slot_left[i]) begin
                slot_left[i] = '0;
                slot_top[i]  = '0;
                slot_wide[i] = '0;
                slot_tall[i] = '0;
                slot_kind[i] = '0;
            end
        endfunction

        function void note_config(t_cfg_wr wr);
            case (wr.index)
                REG_ACTIVE_SLOTS: active_slots = wr.value[6:0];
                REG_COLLIDE_MASK: collide_mask = wr.value;
                REG_BOUNCE_MASK:  bounce_mask  = wr.value;
                default: ;
            endcase
        endfunction

        // Stores update the table; queries push their predicted hit flag.
        function void note_item(t_query q);
            int          left_q;
            int          top_q;
            int          wide_q;
            int          tall_q;
            int          lim;
            int          sl;
            int          st;
            int          sw;
            int          sh;
            bit          x_hit;
            bit          y_hit;
            bit          hit;
            logic [15:0] mask;
            left_q = int'($signed(q.pos_x)) + int'($signed(q.ofs_x));
            top_q  = int'($signed(q.pos_y)) + int'($signed(q.ofs_y));
            wide_q = int'(q.box_w);
            tall_q = int'(q.box_h);
            mask   = '0;
            case (q.op)
                OP_STORE: begin
                    slot_left[q.slot] = 17'(left_q);
                    slot_top[q.slot]  = 17'(top_q);
                    slot_wide[q.slot] = q.box_w;
                    slot_tall[q.slot] = q.box_h;
                    slot_kind[q.slot] = q.kind_id;
                    return;
                end
                OP_COLLIDE: begin
                    mask = collide_mask;
                    case (q.nudge_dir)
                        NUDGE_RIGHT: left_q += int'(ONE_PIXEL);
                        NUDGE_LEFT:  left_q -= int'(ONE_PIXEL);
                        NUDGE_DOWN:  top_q  += int'(ONE_PIXEL);
                        NUDGE_UP:    top_q  -= int'(ONE_PIXEL);
                        default: ;
                    endcase
                end
                OP_BOUNCE: begin
                    mask = bounce_mask;
                    top_q += int'(ONE_PIXEL);
                end
                default: return;
            endcase
            lim = (int'(active_slots) > TABLE_SLOTS) ? TABLE_SLOTS : int'(active_slots);
            hit = 1'b0;
            for (int i = 0; i < lim && !hit; i++) begin
                if (i == int'(q.slot) || !mask[slot_kind[i]]) continue;
                sl = int'(slot_left[i]);
                st = int'(slot_top[i]);
                sw = int'(slot_wide[i]);
                sh = int'(slot_tall[i]);
                // Strict overlap: boxes that only touch do not collide.
                x_hit = ((sl > left_q) ? sl : left_q) <
                        ((sl + sw < left_q + wide_q) ? sl + sw : left_q + wide_q);
                y_hit = ((st > top_q) ? st : top_q) <
                        ((st + sh < top_q + tall_q) ? st + sh : top_q + tall_q);
                hit = x_hit && y_hit;
            end
            pending_hits.push_back(hit);
        endfunction

        function void check_hit(t_result r);
            bit want;
            if (pending_hits.size() == 0) begin
                $error("hit: expected no result, got %0b", r.hit);
                fail_count++;
            end else begin
                want = pending_hits.pop_front();
                if (r.hit !== want) begin
                    $error("hit: expected %0b, got %0b", want, r.hit);
                    fail_count++;
                end
            end
        endfunction
    endclass

endpackage

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// Sprite box collision table testbench
// Directed stores and queries around box edges, nudges and extremes, then
// random items over several register settings and handshake idling patterns,
// including a long result hold-off. Hit flags are checked against a shadow.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import sbc_pkg::*;
    import sbc_tb_pkg::*;

    localparam int HOLDOFF_CYCLES   = 400;
    localparam int RANDOM_PER_PHASE = 112;
    localparam int ARENA            = 64 * PX;

    logic i_clk;
    logic i_rst_n;

    int src_idle_pct     = 0;
    int sink_stall_pct   = 0;
    int holdoff_requests = 0;

    box_table_shadow box_shadow;

    sbc_stream_if #(.T(t_cfg_wr)) cfg_if ();
    sbc_stream_if #(.T(t_query))  query_if ();
    sbc_stream_if #(.T(t_result)) result_if ();

    sprite_box_collision_table #(
        .SLOTS(TABLE_SLOTS)
    ) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_if),
        .i_query  (query_if),
        .o_result (result_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #3ms;
        $display("sprite_box_collision_table: mismatch");
        $finish;
    end

    // Result side: random stalls, plus a long hold-off when one is requested.
    initial begin : result_sink
        int hold_left;
        int served;
        hold_left = 0;
        served    = 0;
        result_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left == 0 && served < holdoff_requests) begin
                hold_left = HOLDOFF_CYCLES;
                served++;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_if.ready <= 1'b0;
            end else begin
                result_if.ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && result_if.valid && result_if.ready) begin
            box_shadow.check_hit(result_if.data);
        end
    end

    function automatic t_query box(logic [1:0] op, int slot, int pos_x, int pos_y,
                                   int ofs_x, int ofs_y, int w, int h, int kind,
                                   logic [2:0] dir);
        t_query q;
        q.op        = op;
        q.slot      = 6'(slot);
        q.pos_x     = 16'(pos_x);
        q.pos_y     = 16'(pos_y);
        q.ofs_x     = 16'(ofs_x);
        q.ofs_y     = 16'(ofs_y);
        q.box_w     = 15'(w);
        q.box_h     = 15'(h);
        q.kind_id   = 4'(kind);
        q.nudge_dir = dir;
        return q;
    endfunction

    // Most items stay in a small arena so that boxes often overlap; the rest
    // use the full range of every field.
    function automatic t_query draw_item();
        t_query q;
        int     r;
        r = $urandom_range(99);
        q.op = (r < 30) ? OP_STORE : (r < 64) ? OP_COLLIDE :
               (r < 95) ? OP_BOUNCE : OP_IGNORED;
        q.slot      = 6'($urandom_range(63));
        q.kind_id   = 4'($urandom_range(15));
        q.nudge_dir = 3'($urandom_range(7));
        if ($urandom_range(99) < 15) begin
            q.pos_x = 16'($urandom);
            q.pos_y = 16'($urandom);
            q.ofs_x = 16'($urandom);
            q.ofs_y = 16'($urandom);
            q.box_w = 15'($urandom);
            q.box_h = 15'($urandom);
        end else begin
            q.pos_x = 16'(int'($urandom_range(2 * ARENA)) - ARENA);
            q.pos_y = 16'(int'($urandom_range(2 * ARENA)) - ARENA);
            q.ofs_x = 16'(int'($urandom_range(16 * PX)) - 8 * PX);
            q.ofs_y = 16'(int'($urandom_range(16 * PX)) - 8 * PX);
            q.box_w = 15'($urandom_range(16 * PX));
            q.box_h = 15'($urandom_range(16 * PX));
        end
        return q;
    endfunction

    task automatic send_item(input t_query q);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            query_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        query_if.valid <= 1'b1;
        query_if.data  <= q;
        do @(posedge i_clk); while (!query_if.ready);
        box_shadow.note_item(q);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
        t_cfg_wr wr;
        wr.index = index;
        wr.value = value;
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= wr;
        do @(posedge i_clk); while (!cfg_if.ready);
        box_shadow.note_config(wr);
    endtask

    task automatic configure(input logic [6:0] act, input logic [15:0] cmask,
                             input logic [15:0] bmask);
        write_reg(REG_ACTIVE_SLOTS, {9'd0, act});
        write_reg(REG_COLLIDE_MASK, cmask);
        write_reg(REG_BOUNCE_MASK, bmask);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // A store returns nothing, so wait out a full walk of the row as well.
    task automatic settle();
        @(negedge i_clk);
        query_if.valid <= 1'b0;
        while (box_shadow.pending_hits.size() != 0) @(posedge i_clk);
        repeat (TABLE_SLOTS + 8) @(posedge i_clk);
    endtask

    initial begin : stimulus
        t_query      directed[$];
        t_query      q;
        logic [6:0]  act;
        logic [15:0] cmask;
        logic [15:0] bmask;
        box_shadow     = new();
        i_rst_n        = 1'b0;
        cfg_if.valid   = 1'b0;
        cfg_if.data    = '0;
        query_if.valid = 1'b0;
        query_if.data  = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Registers are zero after reset, so no slot takes part yet.
        send_item(box(OP_COLLIDE, 0, 0, 0, 0, 0, 4 * PX, 4 * PX, 0, NUDGE_NONE));
        settle();
        configure(7'd4, 16'hFFFF, 16'h0004);

        // Slot 0: 16 px square at the origin. Slot 1: 8 px square at x = 100 px.
        // Slot 2: zero width. Slot 3: the most extreme box the fields allow.
        directed.push_back(box(OP_STORE, 0, 4 * PX, 4 * PX, -4 * PX, -4 * PX,
                               16 * PX, 16 * PX, 1, NUDGE_NONE));
        directed.push_back(box(OP_STORE, 1, 96 * PX, 0, 4 * PX, 0, 8 * PX, 8 * PX, 2,
                               NUDGE_NONE));
        directed.push_back(box(OP_STORE, 2, 0, 0, 0, 0, 0, 16 * PX, 3, NUDGE_NONE));
        directed.push_back(box(OP_STORE, 3, -32768, 32767, -32768, 32767, 32767, 32767,
                               15, NUDGE_NONE));
        // An ignored operation must not overwrite slot 0.
        directed.push_back(box(OP_IGNORED, 0, 500 * PX, 500 * PX, 0, 0, PX, PX, 7,
                               NUDGE_NONE));
        directed.push_back(box(OP_COLLIDE, 5, 16 * PX, 0, 0, 0, 4 * PX, 4 * PX, 0,
                               NUDGE_NONE));
        directed.push_back(box(OP_COLLIDE, 5, 16 * PX, 0, 0, 0, 4 * PX, 4 * PX, 0,
                               NUDGE_LEFT));
        directed.push_back(box(OP_COLLIDE, 5, 0, 16 * PX, 0, 0, 4 * PX, 4 * PX, 0,
                               NUDGE_UP));
        directed.push_back(box(OP_COLLIDE, 5, 0, 16 * PX, 0, 0, 4 * PX, 4 * PX, 0,
                               NUDGE_DOWN));
        directed.push_back(box(OP_COLLIDE, 5, -4 * PX, 4 * PX, 0, 0, 4 * PX, 4 * PX, 0,
                               NUDGE_RIGHT));
        directed.push_back(box(OP_COLLIDE, 5, 4 * PX, -4 * PX, 0, 0, 4 * PX, 4 * PX, 0,
                               NUDGE_DOWN));
        // Bounce moves down whatever the direction, and only kind 2 is tested.
        directed.push_back(box(OP_BOUNCE, 5, 4 * PX, -4 * PX, 0, 0, 4 * PX, 4 * PX, 0,
                               NUDGE_VOID_HI));
        directed.push_back(box(OP_BOUNCE, 5, 100 * PX, -PX, 0, 0, 2 * PX, PX, 0,
                               NUDGE_LEFT));
        directed.push_back(box(OP_COLLIDE, 0, 4 * PX, 4 * PX, 0, 0, 4 * PX, 4 * PX, 0,
                               NUDGE_NONE));
        directed.push_back(box(OP_COLLIDE, 5, 4 * PX, 4 * PX, 0, 0, 0, 4 * PX, 0,
                               NUDGE_NONE));
        directed.push_back(box(OP_COLLIDE, 5, 16 * PX, 0, 0, 0, 4 * PX, 4 * PX, 0,
                               NUDGE_VOID_LO));
        directed.push_back(box(OP_COLLIDE, 5, -32768, 32767, -32768, 32767, 16, 16, 0,
                               NUDGE_NONE));
        directed.push_back(box(OP_COLLIDE, 5, -32768, 32767, -32768, 32767, 16, 16, 0,
                               NUDGE_LEFT));
        directed.push_back(box(OP_COLLIDE, 63, 32767, 32767, 32767, 32767, 32767, 32767,
                               15, NUDGE_UP));
        foreach (directed[i]) send_item(directed[i]);
        settle();

        for (int ph = 0; ph < 8; ph++) begin
            cmask = 16'($urandom);
            bmask = 16'($urandom);
            case (ph)
                0: begin act = 7'd64;  cmask = 16'hFFFF; bmask = 16'hFFFF;
                         src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin act = 7'd127; src_idle_pct = 76; sink_stall_pct = 0;  end
                2: begin act = 7'd0;   cmask = 16'h0000; bmask = 16'h0000;
                         src_idle_pct = 0;  sink_stall_pct = 76; end
                3: begin act = 7'd1;   src_idle_pct = 38; sink_stall_pct = 38; end
                4: begin act = 7'd65;  cmask = 16'hFFFF; bmask = 16'h0000;
                         src_idle_pct = 0;  sink_stall_pct = 0;  end
                5: begin act = 7'($urandom_range(63, 2));
                         src_idle_pct = 76; sink_stall_pct = 0;  end
                6: begin act = 7'd64;  src_idle_pct = 0;  sink_stall_pct = 76; end
                default: begin act = 7'($urandom_range(64));
                         src_idle_pct = 38; sink_stall_pct = 38; end
            endcase
            configure(act, cmask, bmask);
            // The first phase fills every slot before any query reads the table.
            if (ph == 0) begin
                for (int s = 0; s < TABLE_SLOTS; s++) begin
                    q = draw_item();
                    q.op   = OP_STORE;
                    q.slot = 6'(s);
                    send_item(q);
                end
            end
            if (ph == 4) holdoff_requests++;
            repeat (RANDOM_PER_PHASE) send_item(draw_item());
            settle();
        end

        if (box_shadow.fail_count == 0) begin
            $display("sprite_box_collision_table: match");
        end else begin
            $display("sprite_box_collision_table: mismatch");
        end
        $finish;
    end

endmodule
